// File: rtl/wqfd_pkg.sv
// Shared types and constants for the weighted quadratic-form distance unit.
// No dependencies; every other file in rtl/ imports this package.
package wqfd_pkg;

   localparam int DIM      = 4;                  // vector length, 2..4
   localparam int ELEM_CNT = 4;                  // element fields on the input port
   localparam int IN_W     = 16;                 // Q8.8 element and weight width
   localparam int WIDX_W   = 4;                  // width of the weight index field
   localparam int DIFF_W   = IN_W + 1;           // center - point
   localparam int MAT_SIZE = DIM * DIM;
   localparam int MIDX_W   = $clog2(MAT_SIZE);
   localparam int PROD_W   = IN_W + DIFF_W;      // w * diff
   localparam int ROW_W    = PROD_W + $clog2(DIM);
   localparam int QUAD_W   = DIFF_W + ROW_W;     // diff * row
   localparam int OUT_W    = 54;                 // Q30.24 result

   localparam logic [WIDX_W:0] MAT_LIMIT = (WIDX_W + 1)'(MAT_SIZE);

   typedef enum logic {
      FUNC_LOAD     = 1'b0,
      FUNC_DISTANCE = 1'b1
   } func_type;

   typedef logic signed [IN_W-1:0]   elem_vec_type   [ELEM_CNT];
   typedef logic signed [DIFF_W-1:0] diff_vec_type   [DIM];
   typedef logic signed [IN_W-1:0]   weight_mat_type [MAT_SIZE];
   typedef logic signed [PROD_W-1:0] prod_mat_type   [MAT_SIZE];
   typedef logic signed [ROW_W-1:0]  row_vec_type    [DIM];
   typedef logic signed [QUAD_W-1:0] quad_vec_type   [DIM];

endpackage

// File: rtl/weighted_quadratic_form_distance_unit.sv
// Weighted quadratic-form distance unit: d = (c-p)^T W (c-p), Q8.8 in, Q30.24 out.
// Five register stages (difference, products, row sums, diff*row, final sum) lie between
// an input transfer and rsp_valid. Throughput: one item per cycle while rsp_ready is high.
// Weight loads complete in the transfer cycle and produce no result.
// Reset (synchronous, active high) clears all stage valid bits and zeroes the weight store.
// Depends on wqfd_pkg, wqfd_front, wqfd_prod, wqfd_reduce.
module weighted_quadratic_form_distance_unit import wqfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [0:0]               req_func,
   input  logic [WIDX_W-1:0]        req_weight_index,
   input  logic signed [IN_W-1:0]   req_weight_value,
   input  logic signed [IN_W-1:0]   req_point_0,
   input  logic signed [IN_W-1:0]   req_point_1,
   input  logic signed [IN_W-1:0]   req_point_2,
   input  logic signed [IN_W-1:0]   req_point_3,
   input  logic signed [IN_W-1:0]   req_center_0,
   input  logic signed [IN_W-1:0]   req_center_1,
   input  logic signed [IN_W-1:0]   req_center_2,
   input  logic signed [IN_W-1:0]   req_center_3,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_distance_sq
);

   elem_vec_type   point;
   elem_vec_type   center;

   // Stage 1 -> 2
   logic           front_valid;
   logic           prod_ready;
   diff_vec_type   front_diff;
   weight_mat_type front_weight;

   // Stage 2 -> 3
   logic           prod_valid;
   logic           reduce_ready;
   diff_vec_type   prod_diff;
   prod_mat_type   prod_val;

   // Gather the element fields into vectors; elements at or above DIM are unused
   assign point  = '{req_point_0, req_point_1, req_point_2, req_point_3};
   assign center = '{req_center_0, req_center_1, req_center_2, req_center_3};

   // Every stage takes a new item whenever it is empty or its successor advances,
   // so bubbles collapse and a stalled result still lets upstream stages fill.
   wqfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_func         (req_func),
      .in_weight_index (req_weight_index),
      .in_weight_value (req_weight_value),
      .in_point        (point),
      .in_center       (center),
      .out_valid       (front_valid),
      .out_ready       (prod_ready),
      .out_diff        (front_diff),
      .out_weight      (front_weight)
   );

   wqfd_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (prod_ready),
      .in_diff   (front_diff),
      .in_weight (front_weight),
      .out_valid (prod_valid),
      .out_ready (reduce_ready),
      .out_diff  (prod_diff),
      .out_prod  (prod_val)
   );

   // Row sums, diff*row multiply and the final add; the last register drives rsp_*
   wqfd_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (reduce_ready),
      .in_diff   (prod_diff),
      .in_prod   (prod_val),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_sum   (rsp_distance_sq)
   );

   // Input backpressure only when every stage is full and the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low while result path not stalled");

   // A weight load never enters the compute pipeline
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_LOAD)) |=> !front_valid)
      else $error("weight load produced a pipeline item");

   // Hold the first stage while the product stage cannot take it
   assert property (@(posedge clock) disable iff (reset)
      (front_valid && !prod_ready) |=> (front_valid && $stable(front_diff[0])))
      else $error("first stage item lost or changed during stall");

endmodule

// File: rtl/wqfd_front.sv
// Input stage: weight store, weight loads, difference vector and weight snapshot.
// Depends on wqfd_pkg.
module wqfd_front import wqfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [0:0]               in_func,
   input  logic [WIDX_W-1:0]        in_weight_index,
   input  logic signed [IN_W-1:0]   in_weight_value,
   input  elem_vec_type             in_point,
   input  elem_vec_type             in_center,
   output logic                     out_valid,
   input  logic                     out_ready,
   output diff_vec_type             out_diff,
   output weight_mat_type           out_weight
);

   weight_mat_type store_ff;
   weight_mat_type snap_ff;
   diff_vec_type   diff_ff;
   diff_vec_type   diff_in;
   logic           valid_ff;
   logic           accept;
   logic           is_load;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign is_load  = (in_func == FUNC_LOAD);

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         diff_in[i] = DIFF_W'(in_center[i]) - DIFF_W'(in_point[i]);
      end
   end

   // Write one entry per load; drop indexes beyond the matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '{default: '0};
      end else if (accept && is_load && ({1'b0, in_weight_index} < MAT_LIMIT)) begin
         store_ff[in_weight_index[MIDX_W-1:0]] <= in_weight_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= accept && !is_load;
      end
   end

   // Snapshot weights so later loads cannot disturb items in flight
   always_ff @(posedge clock) begin
      if (in_ready) begin
         diff_ff <= diff_in;
         snap_ff <= store_ff;
      end
   end

   assign out_valid  = valid_ff;
   assign out_diff   = diff_ff;
   assign out_weight = snap_ff;

endmodule

// File: rtl/wqfd_prod.sv
// Product stage: one multiplier lane per weight entry, w(i,j) * diff(j).
// Depends on wqfd_pkg.
module wqfd_prod import wqfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  diff_vec_type   in_diff,
   input  weight_mat_type in_weight,
   output logic           out_valid,
   input  logic           out_ready,
   output diff_vec_type   out_diff,
   output prod_mat_type   out_prod
);

   prod_mat_type prod_in;
   prod_mat_type prod_ff;
   diff_vec_type diff_ff;
   logic         valid_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            prod_in[i*DIM + j] = in_weight[i*DIM + j] * in_diff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
         diff_ff <= in_diff;
      end
   end

   assign out_valid = valid_ff;
   assign out_diff  = diff_ff;
   assign out_prod  = prod_ff;

endmodule

// File: rtl/wqfd_reduce.sv
// Reduction stages: row sums, diff(i) * row(i), final sum into the output register.
// Depends on wqfd_pkg.
module wqfd_reduce import wqfd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  diff_vec_type            in_diff,
   input  prod_mat_type            in_prod,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] out_sum
);

   row_vec_type              row_in;
   row_vec_type              row_ff;
   diff_vec_type             diff_ff;
   logic                     row_valid_ff;
   logic                     row_ready;
   quad_vec_type             quad_in;
   quad_vec_type             quad_ff;
   logic                     quad_valid_ff;
   logic                     quad_ready;
   logic signed [OUT_W-1:0]  sum_in;
   logic signed [OUT_W-1:0]  sum_ff;
   logic                     sum_valid_ff;
   logic                     sum_ready;

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign quad_ready = !quad_valid_ff || sum_ready;
   assign row_ready  = !row_valid_ff || quad_ready;
   assign in_ready   = row_ready;

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < DIM; j++) begin
            row_in[i] = row_in[i] + ROW_W'(in_prod[i*DIM + j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         quad_in[i] = diff_ff[i] * row_ff[i];
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < DIM; i++) begin
         sum_in = sum_in + OUT_W'(quad_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= 1'b0;
         quad_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (row_ready) begin
            row_valid_ff <= in_valid;
         end
         if (quad_ready) begin
            quad_valid_ff <= row_valid_ff;
         end
         if (sum_ready) begin
            sum_valid_ff <= quad_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (row_ready) begin
         row_ff  <= row_in;
         diff_ff <= in_diff;
      end
      if (quad_ready) begin
         quad_ff <= quad_in;
      end
      if (sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;

endmodule

// File: tb/weighted_quadratic_form_distance_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_quadratic_form_distance_unit: weight loads and
// distance transfers, a local weight mirror predicting every distance. Depends on wqfd_pkg.
module weighted_quadratic_form_distance_unit_tb import wqfd_pkg::*;;

   // One request as presented on the req_ channel.
   typedef struct packed {
      func_type                           func;
      logic [WIDX_W-1:0]                  weight_index;
      logic [IN_W-1:0]                    weight_value;
      logic [ELEM_CNT-1:0][IN_W-1:0]      point;
      logic [ELEM_CNT-1:0][IN_W-1:0]      center;
   } wqfd_req_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [0:0]              req_func = 1'b0;
   logic [WIDX_W-1:0]       req_weight_index = '0;
   logic signed [IN_W-1:0]  req_weight_value = '0;
   logic signed [IN_W-1:0]  req_point_0 = '0;
   logic signed [IN_W-1:0]  req_point_1 = '0;
   logic signed [IN_W-1:0]  req_point_2 = '0;
   logic signed [IN_W-1:0]  req_point_3 = '0;
   logic signed [IN_W-1:0]  req_center_0 = '0;
   logic signed [IN_W-1:0]  req_center_1 = '0;
   logic signed [IN_W-1:0]  req_center_2 = '0;
   logic signed [IN_W-1:0]  req_center_3 = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_distance_sq;

   // Requests not yet presented, distances not yet returned, and the weight mirror.
   wqfd_req_type            pending_req [$];
   logic signed [OUT_W-1:0] expected_dist [$];
   logic signed [IN_W-1:0]  weight_mirror [MAT_SIZE];

   wqfd_req_type            req_now;
   int                      send_burst = 0;
   int                      send_gap = 0;
   int                      stall_mode = 0;
   int                      stall_timer = 0;
   int                      errors = 0;
   logic signed [OUT_W-1:0] dist_exp;

   weighted_quadratic_form_distance_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_point_0      (req_point_0),
      .req_point_1      (req_point_1),
      .req_point_2      (req_point_2),
      .req_point_3      (req_point_3),
      .req_center_0     (req_center_0),
      .req_center_1     (req_center_1),
      .req_center_2     (req_center_2),
      .req_center_3     (req_center_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance_sq  (rsp_distance_sq)
   );

   always #2 clock = ~clock;

   // Exact quadratic form (c-p)^T W (c-p) over the mirrored weights, in 64-bit math.
   // The magnitude stays below 2^52, so truncating to OUT_W bits is lossless.
   function automatic logic signed [OUT_W-1:0] quad_distance(wqfd_req_type it);
      longint diff [DIM];
      longint row_sum;
      longint acc;
      acc = 0;
      for (int i = 0; i < DIM; i++) begin
         diff[i] = longint'($signed(it.center[i])) - longint'($signed(it.point[i]));
      end
      for (int i = 0; i < DIM; i++) begin
         row_sum = 0;
         for (int j = 0; j < DIM; j++) begin
            row_sum += longint'(weight_mirror[i*DIM+j]) * diff[j];
         end
         acc += diff[i] * row_sum;
      end
      return acc[OUT_W-1:0];
   endfunction

   // Apply one accepted transfer: a load updates the mirror (out-of-range index is
   // dropped), a distance queues its expected result.
   task automatic absorb_request(wqfd_req_type it);
      if (it.func == FUNC_LOAD) begin
         if (it.weight_index < MAT_SIZE) begin
            weight_mirror[it.weight_index] = it.weight_value;
         end
      end else begin
         expected_dist.push_back(quad_distance(it));
      end
   endtask

   // Mostly full-range values, with the extremes, zero and small values favored.
   function automatic logic [IN_W-1:0] pick_q88();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return IN_W'($urandom_range(0, 1023) - 512);
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic wqfd_req_type make_load(int idx, logic [IN_W-1:0] val);
      wqfd_req_type it;
      it.func         = FUNC_LOAD;
      it.weight_index = WIDX_W'(idx);
      it.weight_value = val;
      // point and center are don't-care on a load: fill with noise
      for (int k = 0; k < ELEM_CNT; k++) begin
         it.point[k]  = IN_W'($urandom);
         it.center[k] = IN_W'($urandom);
      end
      return it;
   endfunction

   function automatic wqfd_req_type make_dist(logic [ELEM_CNT-1:0][IN_W-1:0] p,
                                              logic [ELEM_CNT-1:0][IN_W-1:0] c);
      wqfd_req_type it;
      it.func         = FUNC_DISTANCE;
      // index and value are ignored on a distance: fill with noise
      it.weight_index = WIDX_W'($urandom);
      it.weight_value = IN_W'($urandom);
      it.point        = p;
      it.center       = c;
      return it;
   endfunction

   function automatic wqfd_req_type random_dist();
      logic [ELEM_CNT-1:0][IN_W-1:0] p;
      logic [ELEM_CNT-1:0][IN_W-1:0] c;
      for (int k = 0; k < ELEM_CNT; k++) begin
         p[k] = pick_q88();
         c[k] = pick_q88();
      end
      return make_dist(p, c);
   endfunction

   // Block until every queued request is accepted and every distance returned.
   // Sample on the falling edge so updates made at the rising edge are settled.
   task automatic wait_for_drain();
      while (pending_req.size() != 0 || req_valid || expected_dist.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Driver: present queued requests in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         send_burst <= $urandom_range(1, 20);
         send_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_request(req_now);
         end
         if (req_valid && !req_ready) begin
            // hold the current transfer until accepted
         end else if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            req_now = pending_req.pop_front();
            req_func         <= req_now.func;
            req_weight_index <= req_now.weight_index;
            req_weight_value <= req_now.weight_value;
            req_point_0      <= req_now.point[0];
            req_point_1      <= req_now.point[1];
            req_point_2      <= req_now.point[2];
            req_point_3      <= req_now.point[3];
            req_center_0     <= req_now.center[0];
            req_center_1     <= req_now.center[1];
            req_center_2     <= req_now.center[2];
            req_center_3     <= req_now.center[3];
            req_valid        <= 1'b1;
            if (send_burst <= 1) begin
               // roughly a third of bursts run back to back with no gap
               send_burst <= $urandom_range(1, 20);
               send_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               send_burst <= send_burst - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each returned distance against the oldest expectation, and
   // stall rsp_ready in random modes that change whenever stall_timer runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_mode  <= 0;
         stall_timer <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dist.size() == 0) begin
               errors++;
               $display("%0t: unexpected distance, expected none actual %0d",
                        $time, rsp_distance_sq);
            end else begin
               dist_exp = expected_dist.pop_front();
               if (rsp_distance_sq !== dist_exp) begin
                  errors++;
                  $display("%0t: distance_sq mismatch, expected %0d actual %0d",
                           $time, dist_exp, rsp_distance_sq);
               end
            end
         end
         if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= 63;
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_timer[2:0] != 3'd0);
         endcase
      end
   end

   // Stimulus: directed corners, a full drain, then randomized traffic.
   initial begin
      int sent;
      for (int k = 0; k < MAT_SIZE; k++) begin
         weight_mirror[k] = '0;
      end
      // weights start at zero: the largest difference must still give zero
      pending_req.push_back(make_dist({4{16'h7FFF}}, {4{16'h8000}}));
      // fill every entry with the most negative weight
      for (int k = 0; k < MAT_SIZE; k++) begin
         pending_req.push_back(make_load(k, 16'h8000));
      end
      // largest magnitude result: every difference at +65535
      pending_req.push_back(make_dist({4{16'h8000}}, {4{16'h7FFF}}));
      // alternating-sign differences cancel against a uniform matrix
      pending_req.push_back(make_dist({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                                      {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}));
      // asymmetric weights: off-diagonal pair with different values
      pending_req.push_back(make_load(0, 16'h7FFF));
      pending_req.push_back(make_load(1, 16'h0100));
      pending_req.push_back(make_load(DIM, 16'hFE00));
      pending_req.push_back(make_dist({16'h0000, 16'h0000, 16'hFF00, 16'h0100},
                                      {16'h0080, 16'hFF80, 16'h7FFF, 16'h8000}));
      pending_req.push_back(make_dist({16'h1234, 16'hEDCB, 16'h0001, 16'hFFFF},
                                      {16'h1234, 16'hEDCB, 16'h0001, 16'hFFFF}));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // hold off the sender until the pipeline is empty
      wait_for_drain();

      sent = 0;
      while (sent < 450) begin
         if ($urandom_range(0, 39) == 0) begin
            // reload the whole matrix, often with extreme values
            for (int k = 0; k < MAT_SIZE; k++) begin
               pending_req.push_back(make_load(k, ($urandom_range(0, 1) == 0) ?
                                               pick_q88() : IN_W'($urandom)));
            end
            sent += MAT_SIZE;
         end else if ($urandom_range(0, 3) == 0) begin
            pending_req.push_back(make_load($urandom_range(0, 15), pick_q88()));
            sent++;
         end else begin
            pending_req.push_back(random_dist());
            sent++;
         end
         if (sent == 200) begin
            wait_for_drain();
         end
      end

      wait_for_drain();
      // catch any stray result after the last expected one
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legitimate run.
   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
